[rtl/rhc_pkg.sv]
`timescale 1ns / 1ps

package rhc_pkg;

  // Default channel width
  localparam int CHANNEL_BITS_DEF = 8;

  // Hue is carried in sixteenths of a degree
  localparam int HUE_BITS = 13;
  // Quotient of 960 * diff / delta is at most 960
  localparam int HUE_QUOT_BITS = 10;
  // 960 = 1024 - 64
  localparam int HUE_SCALE_SHL_HI = 10;
  localparam int HUE_SCALE_SHL_LO = 6;

  localparam logic [HUE_BITS-1:0] HUE_RED_OFS   = 13'd0;
  localparam logic [HUE_BITS-1:0] HUE_GREEN_OFS = 13'd1920;
  localparam logic [HUE_BITS-1:0] HUE_BLUE_OFS  = 13'd3840;
  localparam logic [HUE_BITS-1:0] HUE_FULL      = 13'd5760;

  // Which channel holds the maximum (ties go red, then green)
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Per-pixel side information carried alongside the dividers
  typedef struct packed {
    logic    achrom;
    sector_t sector;
    logic    neg;
  } hue_tag_t;

endpackage

[rtl/rhc_classify.sv]
`timescale 1ns / 1ps

module rhc_classify
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  output logic [CHANNEL_BITS-1:0] value,
  output logic [CHANNEL_BITS-1:0] delta,
  output logic [CHANNEL_BITS-1:0] abs_diff,
  output hue_tag_t                tag
);

  logic [CHANNEL_BITS-1:0] lo;
  logic [CHANNEL_BITS-1:0] dif_a;
  logic [CHANNEL_BITS-1:0] dif_b;
  logic                    neg;
  sector_t                 sector;

  // Pick the max channel and the pair whose difference sets the hue
  always_comb begin
    if (red >= green && red >= blue) begin
      sector = SEC_RED;
      value  = red;
      dif_a  = green;
      dif_b  = blue;
    end else if (green >= blue) begin
      sector = SEC_GREEN;
      value  = green;
      dif_a  = blue;
      dif_b  = red;
    end else begin
      sector = SEC_BLUE;
      value  = blue;
      dif_a  = red;
      dif_b  = green;
    end
  end

  // Min channel
  always_comb begin
    lo = red;
    if (green < lo) lo = green;
    if (blue < lo) lo = blue;
  end

  assign delta    = value - lo;
  assign neg      = (dif_a < dif_b);
  assign abs_diff = neg ? (dif_b - dif_a) : (dif_a - dif_b);
  // achrom, sector, neg
  assign tag      = {(delta == '0), sector, neg};

endmodule

[rtl/rhc_divider.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage.
// The caller guarantees num_i < (den_i << QUOT_BITS).
module rhc_divider
  import rhc_pkg::*;
#(
  parameter int DEN_BITS  = CHANNEL_BITS_DEF,
  parameter int QUOT_BITS = HUE_QUOT_BITS
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [DEN_BITS+QUOT_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0]           den_i,
  output logic [QUOT_BITS-1:0]          quot_o
);

  localparam int NUM_BITS = DEN_BITS + QUOT_BITS;

  logic [DEN_BITS-1:0]  rem_r [QUOT_BITS];
  logic [DEN_BITS-1:0]  den_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] low_r [QUOT_BITS];
  logic [QUOT_BITS-1:0] quo_r [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [DEN_BITS-1:0]  rem_in;
    logic [DEN_BITS-1:0]  den_in;
    logic [QUOT_BITS-1:0] low_in;
    logic [QUOT_BITS-1:0] quo_in;
    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    diff;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in = num_i[NUM_BITS-1:QUOT_BITS];
      assign low_in = num_i[QUOT_BITS-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_in, low_in[QUOT_BITS-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        den_r[k] <= den_in;
        low_r[k] <= low_in << 1;
        quo_r[k] <= (quo_in << 1) | QUOT_BITS'(take);
      end
    end
  end

  assign quot_o = quo_r[QUOT_BITS-1];

endmodule

[rtl/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps

// RGB to HSV pixel converter.
// Input channel: in_red/in_green/in_blue with in_valid; a transfer happens on
// a rising edge with in_valid high and in_stall low. Result channel: out_hue
// (1/16 degree, 0..5759), out_saturation (full scale = fully saturated),
// out_value (largest channel) and out_achromatic, with out_valid/out_stall.
// Throughput: one pixel per cycle while no result is stalled. Depth is set
// by the two restoring dividers (hue and saturation) that retire one quotient
// bit per stage, across DIV_STAGES = max(CHANNEL_BITS, 10) stages.
// Reset (rst_n low, synchronous) clears every valid bit; nothing else holds
// state between pixels. When the receiver stalls a valid result, the whole
// pipeline freezes and in_stall goes high in the same cycle; payloads hold
// and nothing is lost or repeated.
module rgb_to_hsv_converter
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CHANNEL_BITS-1:0] in_red,
  input  logic [CHANNEL_BITS-1:0] in_green,
  input  logic [CHANNEL_BITS-1:0] in_blue,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HUE_BITS-1:0]     out_hue,
  output logic [CHANNEL_BITS-1:0] out_saturation,
  output logic [CHANNEL_BITS-1:0] out_value,
  output logic                    out_achromatic
);

  localparam int DIV_STAGES = (CHANNEL_BITS > HUE_QUOT_BITS) ? CHANNEL_BITS : HUE_QUOT_BITS;
  localparam int NUM_BITS   = CHANNEL_BITS + DIV_STAGES;

  logic adv;

  // Stage 1: captured pixel
  logic                    s1_valid_r;
  logic [CHANNEL_BITS-1:0] s1_red_r;
  logic [CHANNEL_BITS-1:0] s1_green_r;
  logic [CHANNEL_BITS-1:0] s1_blue_r;

  // Stage 2: extrema and hue pair
  logic [CHANNEL_BITS-1:0] cls_value;
  logic [CHANNEL_BITS-1:0] cls_delta;
  logic [CHANNEL_BITS-1:0] cls_abs_diff;
  hue_tag_t                cls_tag;
  logic                    s2_valid_r;
  logic [CHANNEL_BITS-1:0] s2_value_r;
  logic [CHANNEL_BITS-1:0] s2_delta_r;
  logic [CHANNEL_BITS-1:0] s2_abs_diff_r;
  hue_tag_t                s2_tag_r;

  // Stage 3: divider operands
  logic [NUM_BITS-1:0]     sat_num_nxt;
  logic [NUM_BITS-1:0]     hue_num_nxt;
  logic                    s3_valid_r;
  logic [CHANNEL_BITS-1:0] s3_value_r;
  logic [CHANNEL_BITS-1:0] s3_delta_r;
  logic [NUM_BITS-1:0]     s3_sat_num_r;
  logic [NUM_BITS-1:0]     s3_hue_num_r;
  hue_tag_t                s3_tag_r;

  // Side line running beside the dividers
  logic                    ln_valid_r [DIV_STAGES];
  logic [CHANNEL_BITS-1:0] ln_value_r [DIV_STAGES];
  hue_tag_t                ln_tag_r   [DIV_STAGES];

  logic [DIV_STAGES-1:0]   hue_quot;
  logic [DIV_STAGES-1:0]   sat_quot;

  // Output register
  logic [HUE_BITS-1:0]     hue_q;
  logic [HUE_BITS-1:0]     hue_base;
  logic [HUE_BITS-1:0]     hue_nxt;
  hue_tag_t                tail_tag;
  logic                    out_valid_r;
  logic [HUE_BITS-1:0]     out_hue_r;
  logic [CHANNEL_BITS-1:0] out_sat_r;
  logic [CHANNEL_BITS-1:0] out_value_r;
  logic                    out_achrom_r;

  // Whole pipeline moves unless a held result is being stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
    end
  end

  // Stage 2
  rhc_classify #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_classify (
    .red     (s1_red_r),
    .green   (s1_green_r),
    .blue    (s1_blue_r),
    .value   (cls_value),
    .delta   (cls_delta),
    .abs_diff(cls_abs_diff),
    .tag     (cls_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_value_r    <= cls_value;
      s2_delta_r    <= cls_delta;
      s2_abs_diff_r <= cls_abs_diff;
      s2_tag_r      <= cls_tag;
    end
  end

  // Stage 3: full_scale * delta and 960 * diff by shift and subtract
  assign sat_num_nxt = (NUM_BITS'(s2_delta_r) << CHANNEL_BITS) - NUM_BITS'(s2_delta_r);
  assign hue_num_nxt = (NUM_BITS'(s2_abs_diff_r) << HUE_SCALE_SHL_HI)
                     - (NUM_BITS'(s2_abs_diff_r) << HUE_SCALE_SHL_LO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_value_r   <= s2_value_r;
      s3_delta_r   <= s2_delta_r;
      s3_sat_num_r <= sat_num_nxt;
      s3_hue_num_r <= hue_num_nxt;
      s3_tag_r     <= s2_tag_r;
    end
  end

  // Dividers, run in lockstep
  rhc_divider #(
    .DEN_BITS (CHANNEL_BITS),
    .QUOT_BITS(DIV_STAGES)
  ) u_hue_div (
    .clk   (clk),
    .adv   (adv),
    .num_i (s3_hue_num_r),
    .den_i (s3_delta_r),
    .quot_o(hue_quot)
  );

  rhc_divider #(
    .DEN_BITS (CHANNEL_BITS),
    .QUOT_BITS(DIV_STAGES)
  ) u_sat_div (
    .clk   (clk),
    .adv   (adv),
    .num_i (s3_sat_num_r),
    .den_i (s3_value_r),
    .quot_o(sat_quot)
  );

  // Side line
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ln_valid_r[k] <= 1'b0;
      end else if (adv) begin
        ln_valid_r[k] <= (k == 0) ? s3_valid_r : ln_valid_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ln_value_r[k] <= (k == 0) ? s3_value_r : ln_value_r[(k == 0) ? 0 : k-1];
        ln_tag_r[k]   <= (k == 0) ? s3_tag_r : ln_tag_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Hue assembly: sector offset plus or minus the quotient, wrapped
  assign tail_tag = ln_tag_r[DIV_STAGES-1];
  assign hue_q    = HUE_BITS'(hue_quot[HUE_QUOT_BITS-1:0]);

  always_comb begin
    case (tail_tag.sector)
      SEC_GREEN: hue_base = HUE_GREEN_OFS;
      SEC_BLUE:  hue_base = HUE_BLUE_OFS;
      default: begin
        // red with a negative nonzero term wraps around the circle
        hue_base = (tail_tag.neg && hue_q != '0) ? HUE_FULL : HUE_RED_OFS;
      end
    endcase
    hue_nxt = tail_tag.neg ? (hue_base - hue_q) : (hue_base + hue_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ln_valid_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue_r    <= tail_tag.achrom ? '0 : hue_nxt;
      out_sat_r    <= tail_tag.achrom ? '0 : sat_quot[CHANNEL_BITS-1:0];
      out_value_r  <= ln_value_r[DIV_STAGES-1];
      out_achrom_r <= tail_tag.achrom;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_value      = out_value_r;
  assign out_achromatic = out_achrom_r;

endmodule

[rtl/rhc_checker.sv]
`timescale 1ns / 1ps

module rhc_checker
  import rhc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [CHANNEL_BITS-1:0] in_red,
  input logic [CHANNEL_BITS-1:0] in_green,
  input logic [CHANNEL_BITS-1:0] in_blue,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [HUE_BITS-1:0]     out_hue,
  input logic [CHANNEL_BITS-1:0] out_saturation,
  input logic [CHANNEL_BITS-1:0] out_value,
  input logic                    out_achromatic
);

  // A stalled pixel stays on the input until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_red)
      && $stable(in_green) && $stable(in_blue))
    else $error("input pixel changed while stalled");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue)
      && $stable(out_saturation) && $stable(out_value) && $stable(out_achromatic))
    else $error("result changed while stalled");

  // Input is only held off when a result is actually waiting
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // Gray pixels carry zero hue and saturation
  a_achrom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_achromatic |-> out_hue == '0 && out_saturation == '0)
    else $error("achromatic result with nonzero hue or saturation");

  // Colored pixels have a hue inside the circle, a nonzero value and a nonzero saturation
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_achromatic |-> out_hue < HUE_FULL && out_value != '0
      && out_saturation != '0)
    else $error("colored result out of range");

endmodule

bind rgb_to_hsv_converter rhc_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_rhc_checker (.*);
